FILE: rtl/rsi_pkg.sv
// shared types and constants of the ray-sphere intersection pipeline
// no dependencies
package rsi_pkg;

  localparam int CoordW  = 32;
  localparam int DistW   = 31;
  localparam int RadiusW = 31;
  localparam int ProdW   = 64;
  localparam int WideW   = 128;
  localparam int RootW   = 64;
  localparam int NumW    = 65;
  localparam int QuoW    = 31;
  localparam int FracBits = 16;

  localparam logic [RadiusW-1:0] RadiusReset = 31'd65536;

  typedef struct packed {
    logic signed [CoordW-1:0] origin_x;
    logic signed [CoordW-1:0] origin_y;
    logic signed [CoordW-1:0] origin_z;
    logic signed [CoordW-1:0] dir_x;
    logic signed [CoordW-1:0] dir_y;
    logic signed [CoordW-1:0] dir_z;
    logic [DistW-1:0]         t_limit;
  } ray_req_t;

  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] t_hit;
  } ray_res_t;

  // values that ride along the square root stages
  typedef struct packed {
    logic             miss;
    logic [ProdW-1:0] a;
    logic [ProdW-1:0] bmag;
    logic             bneg;
    logic [DistW-1:0] t_limit;
  } sq_side_t;

  // values that ride along the divider stages
  typedef struct packed {
    logic             miss;
    logic [ProdW-1:0] a;
    logic [DistW-1:0] t_limit;
  } dv_side_t;

endpackage

FILE: rtl/rsi_front.sv
// front end: dot products, partial products of b*b and a*c, discriminant
// depends on rsi_pkg
module rsi_front import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  logic               in_valid,
  input  ray_req_t           req,
  input  logic [RadiusW-1:0] radius,
  output logic               out_valid,
  output logic [WideW-1:0]   disc,
  output sq_side_t           side
);

  // stage 1: component products
  logic                    v1;
  logic signed [ProdW-1:0] dd [3];
  logic signed [ProdW-1:0] oo [3];
  logic signed [ProdW-1:0] od [3];
  logic [2*RadiusW-1:0]    r2;
  logic [DistW-1:0]        tlim1;

  logic signed [CoordW-1:0] oc [3];
  logic signed [CoordW-1:0] dc [3];
  logic signed [ProdW-1:0]  dd_next [3];
  logic signed [ProdW-1:0]  oo_next [3];
  logic signed [ProdW-1:0]  od_next [3];

  assign oc[0] = req.origin_x;
  assign oc[1] = req.origin_y;
  assign oc[2] = req.origin_z;
  assign dc[0] = req.dir_x;
  assign dc[1] = req.dir_y;
  assign dc[2] = req.dir_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd_next[i] = dc[i] * dc[i];
      oo_next[i] = oc[i] * oc[i];
      od_next[i] = oc[i] * dc[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= in_valid;
    end
    if (advance) begin
      dd    <= dd_next;
      oo    <= oo_next;
      od    <= od_next;
      r2    <= radius * radius;
      tlim1 <= req.t_limit;
    end
  end

  // stage 2: sums, signed b split into magnitude and sign, c likewise
  logic             v2;
  logic [ProdW-1:0] a2, bmag2, cmag2;
  logic             bneg2, cneg2;
  logic [DistW-1:0] tlim2;

  logic [ProdW-1:0]        a_next, oosum;
  logic signed [ProdW+1:0] bsum;
  logic                    cneg_next;

  always_comb begin
    a_next    = 64'(dd[0]) + 64'(dd[1]) + 64'(dd[2]);
    oosum     = 64'(oo[0]) + 64'(oo[1]) + 64'(oo[2]);
    bsum      = 66'(od[0]) + 66'(od[1]) + 66'(od[2]);
    cneg_next = {2'b00, r2} > oosum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
    if (advance) begin
      a2    <= a_next;
      bneg2 <= bsum[ProdW+1];
      bmag2 <= bsum[ProdW+1] ? 64'(-bsum) : 64'(bsum);
      cneg2 <= cneg_next;
      cmag2 <= cneg_next ? ({2'b00, r2} - oosum) : (oosum - {2'b00, r2});
      tlim2 <= tlim1;
    end
  end

  // stage 3: 32x32 partial products of bmag*bmag and a*cmag
  logic             v3;
  logic [ProdW-1:0] bll, blh, bhh, all, alh, ahl, ahh;
  logic [ProdW-1:0] a3, bmag3;
  logic             bneg3, cneg3;
  logic [DistW-1:0] tlim3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
    if (advance) begin
      bll   <= bmag2[31:0]  * bmag2[31:0];
      blh   <= bmag2[31:0]  * bmag2[63:32];
      bhh   <= bmag2[63:32] * bmag2[63:32];
      all   <= a2[31:0]  * cmag2[31:0];
      alh   <= a2[31:0]  * cmag2[63:32];
      ahl   <= a2[63:32] * cmag2[31:0];
      ahh   <= a2[63:32] * cmag2[63:32];
      a3    <= a2;
      bmag3 <= bmag2;
      bneg3 <= bneg2;
      cneg3 <= cneg2;
      tlim3 <= tlim2;
    end
  end

  // stage 4: assemble the 128-bit products
  logic             v4;
  logic [WideW-1:0] bb4, ac4;
  logic [ProdW-1:0] a4, bmag4;
  logic             bneg4, cneg4;
  logic [DistW-1:0] tlim4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (advance) begin
      v4 <= v3;
    end
    if (advance) begin
      bb4   <= {bhh, bll} + ({64'd0, blh} << 33);
      ac4   <= {ahh, all} + ({64'd0, alh} << 32) + ({64'd0, ahl} << 32);
      a4    <= a3;
      bmag4 <= bmag3;
      bneg4 <= bneg3;
      cneg4 <= cneg3;
      tlim4 <= tlim3;
    end
  end

  // stage 5: discriminant b*b - a*c, miss on zero direction or disc <= 0
  logic [WideW:0]   diff;
  logic [WideW-1:0] disc_next;

  always_comb begin
    diff      = {1'b0, bb4} - {1'b0, ac4};
    disc_next = cneg4 ? (bb4 + ac4) : diff[WideW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= v4;
    end
    if (advance) begin
      disc         <= disc_next;
      side.miss    <= (a4 == '0) || (!cneg4 && diff[WideW]) || (disc_next == '0);
      side.a       <= a4;
      side.bmag    <= bmag4;
      side.bneg    <= bneg4;
      side.t_limit <= tlim4;
    end
  end

endmodule

FILE: rtl/rsi_sqrt.sv
// pipelined integer square root of the discriminant, one result bit per stage
// depends on rsi_pkg
module rsi_sqrt import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [WideW-1:0] disc,
  input  sq_side_t         in_side,
  output logic             out_valid,
  output logic [RootW-1:0] root,
  output sq_side_t         out_side
);

  logic             vld  [RootW+1];
  logic [WideW-1:0] rem  [RootW+1];
  logic [RootW-1:0] res  [RootW+1];
  sq_side_t         side [RootW+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = disc;
  assign res[0]  = '0;
  assign side[0] = in_side;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    localparam int Bit = RootW - 1 - k;
    logic [WideW-1:0] trial;

    // (res + 2^bit)^2 - res^2
    assign trial = ({64'd0, res[k]} << (Bit + 1)) | ({{(WideW-1){1'b0}}, 1'b1} << (2 * Bit));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
      if (advance) begin
        side[k+1] <= side[k];
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= res[k] | ({{(RootW-1){1'b0}}, 1'b1} << Bit);
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k];
        end
      end
    end
  end

  assign out_valid = vld[RootW];
  assign root      = res[RootW];
  assign out_side  = side[RootW];

endmodule

FILE: rtl/rsi_div.sv
// root choice, range check and pipelined restoring divide, final result register
// depends on rsi_pkg
module rsi_div import rsi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             in_valid,
  input  logic [RootW-1:0] root,
  input  sq_side_t         in_side,
  output logic             out_valid,
  output ray_res_t         res
);

  // choose the nearer positive root numerator
  logic            vs;
  logic [NumW-1:0] ns;
  dv_side_t        sides;

  logic            nb_neg;
  logic [NumW-1:0] n_next;
  logic            miss_next;

  always_comb begin
    nb_neg    = !in_side.bneg && (in_side.bmag != '0);
    n_next    = '0;
    miss_next = in_side.miss;
    if (!nb_neg && (in_side.bmag > root)) begin
      n_next = {1'b0, in_side.bmag - root};
    end else if (!nb_neg) begin
      n_next = {1'b0, in_side.bmag} + {1'b0, root};
      if (n_next == '0) miss_next = 1'b1;
    end else if (root > in_side.bmag) begin
      n_next = {1'b0, root - in_side.bmag};
    end else begin
      miss_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (advance) begin
      vs <= in_valid;
    end
    if (advance) begin
      ns            <= n_next;
      sides.miss    <= miss_next;
      sides.a       <= in_side.a;
      sides.t_limit <= in_side.t_limit;
    end
  end

  // quotient of n*2^16/a reaches 2^31 exactly when n >= a*2^15
  logic             vld  [QuoW+1];
  logic [ProdW-1:0] rem  [QuoW+1];
  logic [QuoW-1:0]  nlo  [QuoW+1];
  logic [QuoW-1:0]  quo  [QuoW+1];
  dv_side_t         side [QuoW+1];

  logic over;
  assign over = {15'd0, ns} >= {1'b0, sides.a, 15'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (advance) begin
      vld[0] <= vs;
    end
    if (advance) begin
      rem[0]          <= {14'd0, ns[NumW-1:QuoW-FracBits]};
      nlo[0]          <= {ns[QuoW-FracBits-1:0], {FracBits{1'b0}}};
      quo[0]          <= '0;
      side[0].miss    <= sides.miss || over;
      side[0].a       <= sides.a;
      side[0].t_limit <= sides.t_limit;
    end
  end

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [ProdW:0] shifted;
    logic [ProdW:0] sub;

    assign shifted = {rem[k], nlo[k][QuoW-1]};
    assign sub     = shifted - {1'b0, side[k].a};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld[k];
      end
      if (advance) begin
        side[k+1] <= side[k];
        nlo[k+1]  <= {nlo[k][QuoW-2:0], 1'b0};
        if (!sub[ProdW]) begin
          rem[k+1] <= sub[ProdW-1:0];
          quo[k+1] <= {quo[k][QuoW-2:0], 1'b1};
        end else begin
          rem[k+1] <= shifted[ProdW-1:0];
          quo[k+1] <= {quo[k][QuoW-2:0], 1'b0};
        end
      end
    end
  end

  // output register
  logic hit_next;
  assign hit_next = !side[QuoW].miss && (quo[QuoW] <= side[QuoW].t_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= vld[QuoW];
    end
    if (advance) begin
      res.hit   <= hit_next;
      res.t_hit <= hit_next ? quo[QuoW] : '0;
    end
  end

endmodule

FILE: rtl/ray_sphere_intersect.sv
// top level of the ray versus centered sphere test: radius register and pipeline
// depends on rsi_pkg, rsi_front, rsi_sqrt, rsi_div
//
// usage:
//   in_valid/in_stall/in_req carries one ray request (origin, direction, t_limit)
//   out_valid/out_stall/out_res returns hit and t_hit for each ray, in order
//   cfg_valid/cfg_ready/cfg_data writes the sphere radius; cfg_ready is always
//   high, write only while the pipeline is empty
// throughput: one ray per cycle while the pipeline is not stalled
// path from request to result: 5 front-end stages (products,
//   sums, partial products, product assembly, discriminant), 64 square root
//   stages at one root bit each, root choice, range check, 31 divide stages at
//   one quotient bit each, and the output register
// stall: the whole pipeline holds while out_valid is high and out_stall is
//   high; in_stall follows that condition, so nothing is dropped or repeated
// reset: rst clears all valid bits and sets the radius to 1.0
module ray_sphere_intersect import rsi_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ray_req_t           in_req,
  output logic               out_valid,
  input  logic               out_stall,
  output ray_res_t           out_res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [RadiusW-1:0] cfg_data
);

  logic [RadiusW-1:0] radius;
  logic               advance;

  logic             fr_valid;
  logic [WideW-1:0] fr_disc;
  sq_side_t         fr_side;

  logic             sq_valid;
  logic [RootW-1:0] sq_root;
  sq_side_t         sq_side;

  assign cfg_ready = 1'b1;
  assign advance   = !(out_valid && out_stall);
  assign in_stall  = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RadiusReset;
    end else if (cfg_valid && cfg_ready) begin
      radius <= cfg_data;
    end
  end

  rsi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (in_valid),
    .req       (in_req),
    .radius    (radius),
    .out_valid (fr_valid),
    .disc      (fr_disc),
    .side      (fr_side)
  );

  rsi_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (fr_valid),
    .disc      (fr_disc),
    .in_side   (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_side  (sq_side)
  );

  rsi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .in_valid  (sq_valid),
    .root      (sq_root),
    .in_side   (sq_side),
    .out_valid (out_valid),
    .res       (out_res)
  );

endmodule
